// ----- design/rcsl_pkg.sv -----
// Shared types and constants of the rated candidate sorted list.
package rcsl_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ID_BITS    = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_SET       = 3'd2,
        OP_LOOKUP    = 3'd3,
        OP_COUNT     = 3'd4,
        OP_VISIT_LIM = 3'd5,
        OP_VISIT_ALL = 3'd6,
        OP_NONE      = 3'd7
    } opcode_t;

    localparam logic [1:0] RC_OK         = 2'd0;
    localparam logic [1:0] RC_NOT_FOUND  = 2'd1;
    localparam logic [1:0] RC_FULL       = 2'd2;
    localparam logic [1:0] RC_BAD_STATUS = 2'd3;

    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        cand_id;
        logic signed [31:0] rating;
        logic [1:0]         new_status;
        logic [5:0]         visit_limit;
    } req_t;

    typedef struct packed {
        logic [1:0]         result_code;
        logic [15:0]        out_id;
        logic signed [31:0] out_rating;
        logic [1:0]         out_status;
        logic [5:0]         good_count;
        logic               is_empty;
        logic               item_valid;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic signed [31:0] rating;
        logic [1:0]         status;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
        logic apply;
        logic emit_item;
        logic emit_final;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic is_visit;
        logic scan_stop;
        logic emit_ok;
        logic out_free;
    } sts_t;

endpackage

// ----- design/rcsl_datapath.sv -----
// Datapath: entry storage, scan index, counters and result register.
module rcsl_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  rcsl_pkg::req_t s_data,
    input  rcsl_pkg::cmd_t cmd,
    output rcsl_pkg::sts_t sts,
    output logic           m_valid,
    output rcsl_pkg::rsp_t m_data,
    input  logic           m_ready
);
    import rcsl_pkg::*;

    entry_t           entries_reg [LIST_DEPTH];
    req_t             req_reg;
    logic [CNT_W-1:0] idx_reg, k_reg, count_reg, bad_reg;
    logic [CNT_W-1:0] count_next, bad_next, good;
    logic             found_reg, ign_reg;
    logic             m_valid_reg;
    rsp_t             m_data_reg;
    entry_t           cur, new_entry;
    logic             at_end, hit, countable_cur, limit_hit, op_visit;
    logic             rating_gt, id_eq, cur_bad, new_bad;
    logic             needs_scan;
    logic [1:0]       final_code;
    rsp_t             rsp_item, rsp_final;

    // Read the entry under the scan index
    assign cur           = entries_reg[idx_reg[IDX_W-1:0]];
    assign at_end        = idx_reg >= count_reg;
    assign rating_gt     = cur.rating > req_reg.rating;
    assign id_eq         = cur.id == ID_BITS'(req_reg.cand_id);
    assign cur_bad       = cur.status == ST_BAD;
    assign new_bad       = req_reg.new_status == ST_BAD;
    assign countable_cur = !(ign_reg && cur_bad);
    assign op_visit      = (req_reg.opcode == OP_VISIT_LIM) || (req_reg.opcode == OP_VISIT_ALL);
    assign limit_hit     = (req_reg.opcode == OP_VISIT_LIM) && (req_reg.visit_limit != 6'd0) &&
                           (7'(k_reg) >= 7'(req_reg.visit_limit));
    assign good          = ign_reg ? (count_reg - bad_reg) : count_reg;

    assign new_entry.id     = ID_BITS'(req_reg.cand_id);
    assign new_entry.rating = req_reg.rating;
    assign new_entry.status = req_reg.new_status;

    // Stop condition of the scan per operation
    always_comb begin
        case (opcode_t'(req_reg.opcode))
            OP_INSERT: hit = !rating_gt;
            OP_REMOVE: hit = id_eq;
            OP_SET:    hit = id_eq;
            OP_LOOKUP: hit = id_eq && countable_cur;
            default:   hit = 1'b0;
        endcase
    end

    // Decide which requests need a scan at all
    always_comb begin
        case (opcode_t'(req_reg.opcode))
            OP_INSERT:    needs_scan = (req_reg.new_status != ST_INVALID) &&
                                       (count_reg < CNT_W'(LIST_DEPTH));
            OP_SET:       needs_scan = req_reg.new_status != ST_INVALID;
            OP_REMOVE,
            OP_LOOKUP,
            OP_VISIT_LIM,
            OP_VISIT_ALL: needs_scan = 1'b1;
            default:      needs_scan = 1'b0;
        endcase
    end

    assign sts.needs_scan = needs_scan;
    assign sts.is_visit   = op_visit;
    assign sts.scan_stop  = op_visit ? (at_end || limit_hit) : (at_end || hit);
    assign sts.emit_ok    = (req_reg.opcode == OP_VISIT_ALL) || countable_cur;
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Closing result code
    always_comb begin
        case (opcode_t'(req_reg.opcode))
            OP_INSERT: begin
                if (req_reg.new_status == ST_INVALID) final_code = RC_BAD_STATUS;
                else if (count_reg >= CNT_W'(LIST_DEPTH) && !found_reg) final_code = RC_FULL;
                else final_code = RC_OK;
            end
            OP_SET: begin
                if (req_reg.new_status == ST_INVALID) final_code = RC_BAD_STATUS;
                else final_code = found_reg ? RC_OK : RC_NOT_FOUND;
            end
            OP_REMOVE,
            OP_LOOKUP: final_code = found_reg ? RC_OK : RC_NOT_FOUND;
            default:   final_code = RC_OK;
        endcase
    end

    // Build result words
    always_comb begin
        rsp_item.result_code = RC_OK;
        rsp_item.out_id      = 16'(cur.id);
        rsp_item.out_rating  = cur.rating;
        rsp_item.out_status  = cur.status;
        rsp_item.good_count  = 6'(good);
        rsp_item.is_empty    = good == '0;
        rsp_item.item_valid  = 1'b1;
        rsp_item.last        = 1'b0;

        rsp_final             = rsp_item;
        rsp_final.result_code = final_code;
        rsp_final.last        = 1'b1;
        if (!(req_reg.opcode == OP_LOOKUP && found_reg)) begin
            rsp_final.out_id     = '0;
            rsp_final.out_rating = '0;
            rsp_final.out_status = '0;
            rsp_final.item_valid = 1'b0;
        end
    end

    // Counter updates on apply
    always_comb begin
        count_next = count_reg;
        bad_next   = bad_reg;
        if (cmd.apply && !at_end || cmd.apply && req_reg.opcode == OP_INSERT) begin
            case (opcode_t'(req_reg.opcode))
                OP_INSERT: begin
                    count_next = count_reg + 1'b1;
                    bad_next   = bad_reg + CNT_W'(new_bad);
                end
                OP_REMOVE: begin
                    count_next = count_reg - 1'b1;
                    bad_next   = bad_reg - CNT_W'(cur_bad);
                end
                OP_SET: bad_next = bad_reg - CNT_W'(cur_bad) + CNT_W'(new_bad);
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            bad_reg     <= '0;
            ign_reg     <= 1'b1;
            idx_reg     <= '0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) ign_reg <= cfg_wdata;
            count_reg <= count_next;
            bad_reg   <= bad_next;
            if (cmd.load) begin
                idx_reg   <= '0;
                k_reg     <= '0;
                found_reg <= 1'b0;
            end else if (cmd.advance) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.emit_item) k_reg <= k_reg + 1'b1;
            // mark a match, or an insert that went in
            if (cmd.apply) found_reg <= !at_end || req_reg.opcode == OP_INSERT;
            if (cmd.emit_item || cmd.emit_final) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers: request, result and entry storage
    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= s_data;
        if (cmd.emit_item) m_data_reg <= rsp_item;
        else if (cmd.emit_final) m_data_reg <= rsp_final;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (cmd.apply) begin
                case (opcode_t'(req_reg.opcode))
                    OP_INSERT: begin
                        if (CNT_W'(i) == idx_reg) entries_reg[i] <= new_entry;
                        else if (i > 0 && CNT_W'(i) > idx_reg && CNT_W'(i) <= count_reg)
                            entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
                    end
                    OP_REMOVE: begin
                        if (!at_end && i < LIST_DEPTH - 1 && CNT_W'(i) >= idx_reg &&
                            CNT_W'(i + 1) < count_reg)
                            entries_reg[i] <= entries_reg[(i < LIST_DEPTH - 1) ? i + 1 : i];
                    end
                    OP_SET: begin
                        if (!at_end && CNT_W'(i) == idx_reg)
                            entries_reg[i].status <= req_reg.new_status;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/rcsl_ctrl.sv -----
// Controller: sequences scan, update and result emission per request.
module rcsl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rcsl_pkg::sts_t sts,
    output rcsl_pkg::cmd_t cmd
);
    import rcsl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_REPLY = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = state_reg == S_IDLE;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!sts.needs_scan) begin
                    state_next = S_REPLY;
                end else if (sts.scan_stop) begin
                    state_next = sts.is_visit ? S_REPLY : S_APPLY;
                end else if (!sts.is_visit) begin
                    cmd.advance = 1'b1;
                end else if (!sts.emit_ok) begin
                    cmd.advance = 1'b1;
                end else if (sts.out_free) begin
                    cmd.emit_item = 1'b1;
                    cmd.advance   = 1'b1;
                end
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (sts.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ----- design/rated_candidate_sorted_list.sv -----
// Top level of the rated candidate sorted list.
// One request is handled at a time. A request scans the list one entry per
// cycle from the head (a visit scan stalls while the output is held); insert
// stops at its slot, id operations at the first match, and insert, remove,
// set status and lookup then latch the outcome in an apply step, insert and
// remove moving all entries at once and set status writing the matched entry.
// Visits emit one result per cycle while the output is taken. Count and
// rejected requests need no scan and go straight to the reply. Results leave
// through a registered output stage; the good count is kept by counters.
module rated_candidate_sorted_list (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  rcsl_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rcsl_pkg::rsp_t m_data
);
    import rcsl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rcsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rcsl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .m_ready   (m_ready)
    );

    // Taking a request drops s_ready in the cycle after it
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // Results without a candidate always close the run
    a_plain_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.item_valid |-> m_data.last)
        else $error("non-item result not marked last");

    // Empty flag follows the count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.good_count == 6'd0)))
        else $error("empty flag disagrees with count");

endmodule

// ----- tb/rcsl_checker.sv -----
// Checker for the rated candidate sorted list: mirrors the list and compares each result.
module rcsl_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           s_valid,
    input  logic           s_ready,
    input  rcsl_pkg::req_t s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  rcsl_pkg::rsp_t m_data,
    output int             fail_count,
    output int             pending
);
    import rcsl_pkg::*;

    entry_t         shadow_list[LIST_DEPTH];
    int             shadow_len;
    logic           skip_bad;
    rsp_t           expected_rsps[$];

    // an entry counts unless bad entries are ignored and it is bad
    function automatic bit is_countable(int i);
        return !(skip_bad && shadow_list[i].status == ST_BAD);
    endfunction

    // append one expected result
    function automatic void queue_rsp(rsp_t r);
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    function automatic rsp_t make_rsp(logic [1:0] code, bit has, int idx, bit fin);
        rsp_t r;
        int n;
        n = 0;
        for (int i = 0; i < shadow_len; i++)
            if (is_countable(i)) n++;
        r = '0;
        r.result_code = code;
        if (has) begin
            r.out_id     = shadow_list[idx].id;
            r.out_rating = shadow_list[idx].rating;
            r.out_status = shadow_list[idx].status;
        end
        r.good_count = n[5:0];
        r.is_empty   = (n == 0);
        r.item_valid = has;
        r.last       = fin;
        return r;
    endfunction

    function automatic int locate_id(logic [15:0] id, bit honor_bad);
        for (int i = 0; i < shadow_len; i++) begin
            if (honor_bad && !is_countable(i)) continue;
            if (shadow_list[i].id == id) return i;
        end
        return -1;
    endfunction

    // apply one request to the mirror and queue its results
    task automatic predict_request(req_t q);
        int pos;
        int k;
        logic [1:0] code;
        code = RC_OK;
        case (opcode_t'(q.opcode))
            OP_INSERT: begin
                if (q.new_status == ST_INVALID) code = RC_BAD_STATUS;
                else if (shadow_len >= LIST_DEPTH) code = RC_FULL;
                else begin
                    pos = 0;
                    while (pos < shadow_len && shadow_list[pos].rating > q.rating) pos++;
                    for (int i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = '{q.cand_id, q.rating, q.new_status};
                    shadow_len++;
                end
                queue_rsp(make_rsp(code, 0, 0, 1));
            end
            OP_REMOVE: begin
                pos = locate_id(q.cand_id, 0);
                if (pos < 0) code = RC_NOT_FOUND;
                else begin
                    for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
                queue_rsp(make_rsp(code, 0, 0, 1));
            end
            OP_SET: begin
                if (q.new_status == ST_INVALID) code = RC_BAD_STATUS;
                else begin
                    pos = locate_id(q.cand_id, 0);
                    if (pos < 0) code = RC_NOT_FOUND;
                    else shadow_list[pos].status = q.new_status;
                end
                queue_rsp(make_rsp(code, 0, 0, 1));
            end
            OP_LOOKUP: begin
                pos = locate_id(q.cand_id, skip_bad);
                if (pos < 0) queue_rsp(make_rsp(RC_NOT_FOUND, 0, 0, 1));
                else queue_rsp(make_rsp(RC_OK, 1, pos, 1));
            end
            OP_VISIT_LIM, OP_VISIT_ALL: begin
                k = 0;
                for (int i = 0; i < shadow_len; i++) begin
                    if (q.opcode == OP_VISIT_LIM) begin
                        if (q.visit_limit != 0 && k >= q.visit_limit) break;
                        if (!is_countable(i)) continue;
                    end
                    queue_rsp(make_rsp(RC_OK, 1, i, 0));
                    k++;
                end
                queue_rsp(make_rsp(RC_OK, 0, 0, 1));
            end
            default: queue_rsp(make_rsp(RC_OK, 0, 0, 1));
        endcase
    endtask

    // watch both channels at each rising edge
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            shadow_len = 0;
            skip_bad   = 1'b1;
            fail_count = 0;
            expected_rsps.delete();
        end else begin
            if (cfg_we) skip_bad = cfg_wdata;
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, m_data);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_request(s_data);
        end
        pending = expected_rsps.size();
    end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives requests and configuration, and gives the verdict.
module tb_top;
    import rcsl_pkg::*;

    logic   aclk;
    logic   aresetn;
    logic   cfg_we;
    logic   cfg_wdata;
    logic   s_valid;
    logic   s_ready;
    req_t   s_data;
    logic   m_valid;
    logic   m_ready;
    rsp_t   m_data;
    int     fail_count;
    int     pending;
    bit     calm;
    logic [15:0] id_pool[8];

    rated_candidate_sorted_list dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rcsl_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // stall the result side in short bursts
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    // present one request and hold it until taken
    task automatic send_request(opcode_t op, logic [15:0] id, logic [31:0] rate,
                                logic [1:0] st, logic [5:0] lim);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        s_valid <= 1;
        s_data  <= '{op, id, rate, st, lim};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 0;
    endtask

    // let all results drain, then write the register
    task automatic write_ignore_bad(logic v);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_request();
        int pick;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
        if (pick < 40)
            send_request(OP_INSERT, id, $urandom, ($urandom_range(0, 15) == 0) ? ST_INVALID
                         : 2'($urandom_range(0, 2)), 6'($urandom));
        else if (pick < 55) send_request(OP_REMOVE, id, $urandom, 2'($urandom), 6'($urandom));
        else if (pick < 70) send_request(OP_SET, id, $urandom, 2'($urandom), 6'($urandom));
        else if (pick < 80) send_request(OP_LOOKUP, id, $urandom, 2'($urandom), 6'($urandom));
        else if (pick < 85) send_request(OP_COUNT, id, $urandom, 2'($urandom), 6'($urandom));
        else if (pick < 93) send_request(OP_VISIT_LIM, id, $urandom, 2'($urandom),
                                         6'($urandom_range(0, 63)));
        else if (pick < 98) send_request(OP_VISIT_ALL, id, $urandom, 2'($urandom), 6'($urandom));
        else send_request(OP_NONE, id, $urandom, 2'($urandom), 6'($urandom));
    endtask

    initial begin
        aresetn = 0; cfg_we = 0; cfg_wdata = 0; s_valid = 0; s_data = '0; calm = 0;
        foreach (id_pool[i]) id_pool[i] = 16'($urandom);
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        repeat (8) @(negedge aclk);
        aresetn = 1;
        // directed: empty list, extremes, ties, duplicates, invalid status
        write_ignore_bad(1);
        send_request(OP_COUNT, 0, 0, 0, 0);
        send_request(OP_REMOVE, 16'h1234, 0, 0, 0);
        send_request(OP_VISIT_ALL, 0, 0, 0, 0);
        send_request(OP_INSERT, 16'hFFFF, 32'h7FFFFFFF, 0, 0);
        send_request(OP_INSERT, 16'h0000, 32'h80000000, 2, 0);
        send_request(OP_INSERT, 16'h0001, 32'h00010000, 1, 0);
        send_request(OP_INSERT, 16'h0001, 32'h00010000, 0, 0);
        send_request(OP_INSERT, 16'h0002, 0, ST_INVALID, 0);
        send_request(OP_LOOKUP, 16'h0000, 0, 0, 0);
        send_request(OP_LOOKUP, 16'h0001, 0, 0, 0);
        send_request(OP_SET, 16'h0001, 0, ST_INVALID, 0);
        send_request(OP_SET, 16'h0001, 0, 2, 0);
        send_request(OP_SET, 16'h5555, 0, 1, 0);
        send_request(OP_VISIT_LIM, 0, 0, 0, 0);
        send_request(OP_VISIT_LIM, 0, 0, 0, 1);
        send_request(OP_VISIT_ALL, 0, 0, 0, 63);
        send_request(OP_NONE, 16'hFFFF, 32'hFFFFFFFF, 3, 63);
        write_ignore_bad(0);
        send_request(OP_LOOKUP, 16'h0000, 0, 0, 0);
        send_request(OP_VISIT_LIM, 0, 0, 0, 32);
        send_request(OP_REMOVE, 16'h0001, 0, 0, 0);
        // fill to capacity, then overflow
        for (int i = 0; i < 33; i++)
            send_request(OP_INSERT, 16'($urandom), $urandom, 2'($urandom_range(0, 2)), 0);
        send_request(OP_VISIT_ALL, 0, 0, 0, 0);
        write_ignore_bad(1);
        for (int i = 0; i < 34; i++) send_request(OP_REMOVE, id_pool[0], 0, 0, 0);
        // random phases under both settings
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3) calm = 1;
            for (int n = 0; n < 100; n++) random_request();
            write_ignore_bad(phase[0]);
        end
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
